FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the brush blend weight block.
// Depends on nothing; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBF_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBF_ASSERT(label, clk, rst_n, prop, msg)
`define BBF_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/bbf_pkg.sv
// Package for the brush blend weight block: widths, register indexes, sizes.
// Depends on nothing.
package bbf_pkg;
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned SizeBits     = 8;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 32;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_SHAPE   = 3'd0,
    REG_CENTRE_X = 3'd1,
    REG_CENTRE_Y = 3'd2,
    REG_SIZE    = 3'd3,
    REG_FEATHER = 3'd4
  } cfg_reg_e;

  localparam logic SHAPE_ROUND = 1'b0;
endpackage

FILE: rtl/core/bbf_sqrt.sv
// Pipelined integer square root, PerStage result bits per stage.
// Depends on bbf_pkg; carries a side word alongside each value.
module bbf_sqrt import bbf_pkg::*; #(
  parameter int unsigned InBits   = 48,
  parameter int unsigned SideBits = 8,
  parameter int unsigned PerStage = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [InBits-1:0]    rad_i,
  input  logic [SideBits-1:0]  side_i,
  output logic                 valid_o,
  output logic [InBits/2-1:0]  root_o,
  output logic [SideBits-1:0]  side_o
);
  localparam int unsigned RootBits = InBits / 2;
  localparam int unsigned NStage   = (RootBits + PerStage - 1) / PerStage;
  localparam int unsigned RemBits  = RootBits + 2;

  logic [NStage:0]               vld_q;
  logic [InBits-1:0]             rad_q  [NStage+1];
  logic [RemBits-1:0]            rem_q  [NStage+1];
  logic [RootBits-1:0]           root_q [NStage+1];
  logic [SideBits-1:0]           side_q [NStage+1];

  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < NStage; s++) begin : g_stage
    logic [InBits-1:0]   rad_d;
    logic [RemBits-1:0]  rem_d;
    logic [RootBits-1:0] root_d;
    always_comb begin
      logic [RemBits-1:0] trial;
      rad_d  = rad_q[s];
      rem_d  = rem_q[s];
      root_d = root_q[s];
      for (int k = 0; k < PerStage; k++) begin
        if (s * PerStage + k < RootBits) begin
          rem_d  = {rem_d[RemBits-3:0], rad_d[InBits-1 -: 2]};
          rad_d  = {rad_d[InBits-3:0], 2'b00};
          trial  = {root_d, 2'b01};
          if (rem_d >= trial) begin
            rem_d  = rem_d - trial;
            root_d = {root_d[RootBits-2:0], 1'b1};
          end else begin
            root_d = {root_d[RootBits-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[s+1]  <= rad_d;
      rem_q[s+1]  <= rem_d;
      root_q[s+1] <= root_d;
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[NStage];
  assign root_o  = root_q[NStage];
  assign side_o  = side_q[NStage];
endmodule

FILE: rtl/core/bbf_div.sv
// Pipelined restoring divider, a few quotient bits per stage.
// Depends on bbf_pkg; carries a side word alongside each value.
module bbf_div import bbf_pkg::*; #(
  parameter int unsigned NumBits  = 28,
  parameter int unsigned DenBits  = 18,
  parameter int unsigned SideBits = 2,
  parameter int unsigned PerStage = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  input  logic [SideBits-1:0] side_i,
  output logic                valid_o,
  output logic [NumBits-1:0]  quot_o,
  output logic [SideBits-1:0] side_o
);
  localparam int unsigned NStage  = (NumBits + PerStage - 1) / PerStage;
  localparam int unsigned RemBits = DenBits + 1;

  logic [NStage:0]       vld_q;
  logic [NumBits-1:0]    num_q  [NStage+1];
  logic [DenBits-1:0]    den_q  [NStage+1];
  logic [RemBits-1:0]    rem_q  [NStage+1];
  logic [SideBits-1:0]   side_q [NStage+1];

  assign vld_q[0]  = valid_i;
  assign num_q[0]  = num_i;
  assign den_q[0]  = den_i;
  assign rem_q[0]  = '0;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < NStage; s++) begin : g_stage
    logic [NumBits-1:0] num_d;
    logic [RemBits-1:0] rem_d;
    always_comb begin
      num_d = num_q[s];
      rem_d = rem_q[s];
      for (int k = 0; k < PerStage; k++) begin
        if (s * PerStage + k < NumBits) begin
          rem_d = {rem_d[RemBits-2:0], num_d[NumBits-1]};
          num_d = {num_d[NumBits-2:0], 1'b0};
          if (rem_d >= {1'b0, den_q[s]}) begin
            rem_d    = rem_d - {1'b0, den_q[s]};
            num_d[0] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[s+1]  <= num_d;
      den_q[s+1]  <= den_q[s];
      rem_q[s+1]  <= rem_d;
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[NStage];
  assign quot_o  = num_q[NStage];
  assign side_o  = side_q[NStage];
endmodule

FILE: rtl/core/brush_blend_factor_top.sv
// Brush blend weight: distance, inside test, square root, falloff division.
// Depends on bbf_pkg, bbf_sqrt, bbf_div and assert_macros.svh.
//
//  channel   handshake              payload
//  command   start / busy           cell_x_i, cell_y_i
//  result    done_o (strobe)        blend_weight_o
//  config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One cell enters every cycle and passes, at default sizes, through three front
// stages, six root stages (four bits each, two in the last), one select stage,
// nine division stages (four quotient bits each, one in the last) and the output
// register.
// Reset clears the valid bits and sets the registers to round, centre 0, size 1,
// feather 0. busy stays low: the pipeline never stalls.
`include "assert_macros.svh"
module brush_blend_factor_top import bbf_pkg::*; #(
  parameter int unsigned COORD_BITS       = CoordBitsDef,
  parameter int unsigned WEIGHT_FRAC_BITS = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [COORD_BITS-1:0]       cell_x_i,
  input  logic [COORD_BITS-1:0]       cell_y_i,
  output logic                        done_o,
  output logic [WEIGHT_FRAC_BITS:0]   blend_weight_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIdxBits-1:0]       cfg_index_i,
  input  logic [CfgDataBits-1:0]      cfg_data_i
);
  localparam int unsigned DBits   = COORD_BITS + 1;       // half-cell distance
  localparam int unsigned SBits   = 2 * DBits + 1;        // dx^2 + dy^2
  localparam int unsigned RadBits = 2 * ((SBits + 16 + 1) / 2);
  localparam int unsigned RBits   = RadBits / 2;
  localparam int unsigned EBits   = (RBits > DBits) ? RBits : DBits;
  localparam int unsigned BandBits = SizeBits + 9;
  localparam int unsigned NumBits = BandBits + WEIGHT_FRAC_BITS;
  localparam int unsigned LimBits = 2 * (SizeBits + 4);
  localparam int unsigned ProdBits = SBits + 7;
  localparam logic [WEIGHT_FRAC_BITS:0] WeightOne =
    (WEIGHT_FRAC_BITS+1)'(1) << WEIGHT_FRAC_BITS;

  // configuration
  logic                    shape_q;
  logic [COORD_BITS-1:0]   cx_q, cy_q;
  logic [SizeBits-1:0]     size_q, feather_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q   <= SHAPE_ROUND;
      cx_q      <= '0;
      cy_q      <= '0;
      size_q    <= SizeBits'(1);
      feather_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SHAPE:    shape_q   <= cfg_data_i[0];
        REG_CENTRE_X: cx_q      <= cfg_data_i[COORD_BITS-1:0];
        REG_CENTRE_Y: cy_q      <= cfg_data_i[COORD_BITS-1:0];
        REG_SIZE:     size_q    <= cfg_data_i[SizeBits-1:0];
        REG_FEATHER:  feather_q <= cfg_data_i[SizeBits-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: half-cell distances
  logic             v1_q;
  logic [DBits-1:0] dx_q, dy_q;
  logic [DBits-1:0] ax, ay, bx, by;
  assign ax = {cx_q, size_q[0]};
  assign ay = {cy_q, size_q[0]};
  assign bx = {cell_x_i, 1'b0};
  assign by = {cell_y_i, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    dx_q <= (ax > bx) ? ax - bx : bx - ax;
    dy_q <= (ay > by) ? ay - by : by - ay;
  end

  // stage 2: squared radius, square-brush max
  logic             v2_q;
  logic [SBits-1:0] s_q;
  logic [DBits-1:0] dm_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    s_q  <= SBits'(dx_q) * SBits'(dx_q) + SBits'(dy_q) * SBits'(dy_q);
    dm_q <= (dx_q > dy_q) ? dx_q : dy_q;
  end

  // stage 3: inside test, then root; side word carries the inside outcome and the square-brush max
  logic                v3_q, in3_q;
  logic [SBits-1:0]    s3_q;
  logic [DBits-1:0]    dm3_q;
  logic [LimBits-1:0]  lim;
  logic [SizeBits+3:0] lw;
  assign lw  = (SizeBits+4)'(size_q) * 4'd10 + 1'b1;
  assign lim = lw * lw;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    s3_q  <= s_q;
    dm3_q <= dm_q;
    if (shape_q == SHAPE_ROUND)
      in3_q <= (ProdBits'(s_q) * 7'd100) <= ProdBits'(lim);
    else
      in3_q <= dm_q <= DBits'(size_q);
  end

  logic             v4;
  logic [RBits-1:0] r4;
  logic [DBits:0]   side4;
  bbf_sqrt #(.InBits(RadBits), .SideBits(DBits + 1), .PerStage(4)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (v3_q),
    .rad_i   (RadBits'({s3_q, 16'd0})),
    .side_i  ({in3_q, dm3_q}),
    .valid_o (v4),
    .root_o  (r4),
    .side_o  (side4)
  );

  // stage 5: excess and band, select the division operands
  logic                v5_q, in5_q, zero5_q;
  logic [NumBits-1:0]  num5_q;
  logic [BandBits-1:0] band5_q;
  logic [EBits-1:0]    e5;
  logic [BandBits-1:0] band5;
  always_comb begin
    if (shape_q == SHAPE_ROUND) begin
      band5 = BandBits'({feather_q, 9'd0});
      e5    = (r4 > RBits'({size_q, 8'd0})) ? EBits'(r4 - RBits'({size_q, 8'd0})) : '0;
    end else begin
      band5 = BandBits'({feather_q, 1'b0});
      e5    = EBits'(side4[DBits-1:0] - DBits'(size_q));
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4;
  end
  always_ff @(posedge clk_i) begin
    in5_q   <= side4[DBits];
    zero5_q <= (band5 == '0) || (e5 > EBits'(band5));
    num5_q  <= NumBits'(band5 - BandBits'(e5)) << WEIGHT_FRAC_BITS;
    band5_q <= band5;
  end

  logic               v6;
  logic [NumBits-1:0] q6;
  logic [1:0]         side6;
  bbf_div #(.NumBits(NumBits), .DenBits(BandBits), .SideBits(2), .PerStage(4)) u_div (
    .clk_i, .rst_ni,
    .valid_i (v5_q),
    .num_i   (num5_q),
    .den_i   ((band5_q == '0) ? BandBits'(1) : band5_q),
    .side_i  ({in5_q, zero5_q}),
    .valid_o (v6),
    .quot_o  (q6),
    .side_o  (side6)
  );

  // output register
  logic                       done_q;
  logic [WEIGHT_FRAC_BITS:0]  w_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= v6;
  end
  always_ff @(posedge clk_i) begin
    if (side6[1])      w_q <= WeightOne;
    else if (side6[0]) w_q <= '0;
    else               w_q <= q6[WEIGHT_FRAC_BITS:0];
  end
  assign done_o         = done_q;
  assign blend_weight_o = w_q;

  `BBF_ASSERT(a_weight_range, clk_i, rst_ni, done_o |-> blend_weight_o <= WeightOne, "weight above one")
  `BBF_ASSERT(a_front_valid, clk_i, rst_ni, start |=> v1_q, "front stage lost a word")
  `BBF_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |-> !done_o, "result strobe during reset")
endmodule
